// ===== rtl/chained_hash_set_macros.svh =====
// Assertion macros for the chained hash set.
`ifndef CHAINED_HASH_SET_MACROS_SVH
`define CHAINED_HASH_SET_MACROS_SVH
`ifndef SYNTHESIS
`define CHS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define CHS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CHS_ASSERT_NOW(label, ante, cons, msg)
`define CHS_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/chs_pkg.sv =====
// Shared widths, status codes and register constants of the chained hash set.
package chs_pkg;
  localparam int KEY_W      = 32;
  localparam int CFG_W      = 11;
  localparam int STATUS_W   = 2;
  localparam int NODE_IDX_W = 12;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  localparam logic            REG_BUCKET_COUNT = 1'b0;
  localparam logic [CFG_W-1:0] BUCKET_COUNT_RST = 11'd1021;
endpackage

// ===== rtl/chained_hash_set.sv =====
// Hash set of 32-bit keys with separate chaining over a bump-allocated node pool.
// After reset the block sweeps the bucket head memory, one entry a cycle, over
// all MAX_BUCKETS entries before it takes its first word. One request at a time:
// the bucket (key modulo bucket_count, clamped to 1..MAX_BUCKETS) comes from a
// divider giving two quotient bits a cycle; the head is read in S_HEAD and checked
// in S_HCHK, then each chain node visited is read on the node memory's read port,
// and S_DONE moves the result into the output register once that is free. The
// next word is taken while a result still waits.
`include "chained_hash_set_macros.svh"

module chained_hash_set #(
  parameter int MAX_BUCKETS = 1024,
  parameter int POOL_NODES  = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_kind,
  input  logic [chs_pkg::KEY_W-1:0]       in_key,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [chs_pkg::STATUS_W-1:0]    out_status,
  output logic [chs_pkg::NODE_IDX_W-1:0]  out_node_index,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [chs_pkg::PADDR_W-1:0]     paddr,
  input  logic [chs_pkg::PDATA_W-1:0]     pwdata,
  output logic [chs_pkg::PDATA_W-1:0]     prdata,
  output logic                            pready
);
  import chs_pkg::*;

  localparam int BKT_W   = $clog2(MAX_BUCKETS);
  localparam int LINK_W  = $clog2(POOL_NODES + 1);
  localparam int NODE_W  = $clog2(POOL_NODES);
  localparam int NODE_MW = KEY_W + LINK_W;
  localparam int STEP_N  = KEY_W / 2;
  localparam int STEP_W  = $clog2(STEP_N);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_HEAD  = 3'd3;
  localparam logic [2:0] S_HCHK  = 3'd4;
  localparam logic [2:0] S_NCHK  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [LINK_W-1:0]  head_mem [MAX_BUCKETS];
  logic [NODE_MW-1:0] node_mem [POOL_NODES];

  logic [2:0]          state_r, state_nxt;
  logic [CFG_W-1:0]    bc_r;
  logic [BKT_W-1:0]    clr_r, clr_nxt;
  logic [LINK_W-1:0]   nu_r, nu_nxt;
  logic                kind_r, kind_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [KEY_W-1:0]    dvd_r, dvd_nxt;
  logic [CFG_W-1:0]    rem_r, rem_nxt, rem_step;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [BKT_W-1:0]    bkt_r, bkt_nxt;
  logic [STATUS_W-1:0] res_st_r, res_st_nxt;
  logic [NODE_W-1:0]   res_nd_r, res_nd_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_st_r, out_st_nxt;
  logic [NODE_W-1:0]   out_nd_r, out_nd_nxt;

  logic [LINK_W-1:0]   head_q;
  logic [NODE_MW-1:0]  node_q;
  logic [CFG_W-1:0]    n_eff;
  logic [LINK_W-1:0]   cur_link;
  logic [NODE_W-1:0]   nd_addr;
  logic                link_ok, key_hit, walking, miss, do_ins;
  logic                head_we;
  logic [BKT_W-1:0]    head_wa;
  logic [LINK_W-1:0]   head_wd;
  logic                cfg_we;

  // one restoring division step on the running remainder
  function automatic logic [CFG_W-1:0] div_bit(logic [CFG_W-1:0] r, logic b,
                                               logic [CFG_W-1:0] n);
    logic [CFG_W:0] t;
    t = {r, b};
    if (t >= {1'b0, n}) t = t - {1'b0, n};
    return t[CFG_W-1:0];
  endfunction

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_BUCKET_COUNT);
  assign prdata = (paddr[2] == REG_BUCKET_COUNT) ? PDATA_W'(bc_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bc_r <= BUCKET_COUNT_RST;
    end else if (cfg_we) begin
      bc_r <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    if (bc_r == '0) begin
      n_eff = CFG_W'(1);
    end else if (32'(bc_r) > 32'(MAX_BUCKETS)) begin
      n_eff = CFG_W'(MAX_BUCKETS);
    end else begin
      n_eff = bc_r;
    end
  end

  assign rem_step = div_bit(div_bit(rem_r, dvd_r[KEY_W-1], n_eff), dvd_r[KEY_W-2], n_eff);

  // chain walk: link comes from the head read first, then from each node read
  assign walking  = (state_r == S_HCHK) || (state_r == S_NCHK);
  assign cur_link = (state_r == S_HCHK) ? head_q : node_q[LINK_W-1:0];
  assign key_hit  = (state_r == S_NCHK) && (node_q[NODE_MW-1:LINK_W] == key_r);
  assign link_ok  = (cur_link != '0) && ((cur_link - LINK_W'(1)) < nu_r);
  assign nd_addr  = NODE_W'(cur_link - LINK_W'(1));
  assign miss     = walking && !key_hit && !link_ok;
  assign do_ins   = miss && kind_r && (nu_r < LINK_W'(POOL_NODES));

  assign head_we = (state_r == S_CLEAR) || do_ins;
  assign head_wa = (state_r == S_CLEAR) ? clr_r : bkt_r;
  assign head_wd = (state_r == S_CLEAR) ? '0 : nu_r + LINK_W'(1);

  always_ff @(posedge clk) begin
    head_q <= head_mem[bkt_r];
    if (head_we) head_mem[head_wa] <= head_wd;
  end

  always_ff @(posedge clk) begin
    node_q <= node_mem[nd_addr];
    if (do_ins) node_mem[nu_r[NODE_W-1:0]] <= {key_r, head_q};
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    nu_nxt        = nu_r;
    kind_nxt      = kind_r;
    key_nxt       = key_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    bkt_nxt       = bkt_r;
    res_st_nxt    = res_st_r;
    res_nd_nxt    = res_nd_r;
    out_valid_nxt = out_valid_r;
    out_st_nxt    = out_st_r;
    out_nd_nxt    = out_nd_r;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + BKT_W'(1);
        if (clr_r == BKT_W'(MAX_BUCKETS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt  = in_kind;
          key_nxt   = in_key;
          dvd_nxt   = in_key;
          rem_nxt   = '0;
          step_nxt  = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt  = rem_step;
        dvd_nxt  = {dvd_r[KEY_W-3:0], 2'b00};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(STEP_N - 1)) begin
          bkt_nxt   = BKT_W'(rem_step);
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        state_nxt = S_HCHK;
      end
      S_HCHK, S_NCHK: begin
        if (key_hit) begin
          res_st_nxt = ST_FOUND;
          // the hit node's own link is not held, so recover its index from the read address
          res_nd_nxt = res_nd_r;
          state_nxt  = S_DONE;
        end else if (link_ok) begin
          res_nd_nxt = nd_addr;
          state_nxt  = S_NCHK;
        end else begin
          state_nxt = S_DONE;
          res_nd_nxt = '0;
          if (!kind_r) begin
            res_st_nxt = ST_NOT_FOUND;
          end else if (do_ins) begin
            res_st_nxt = ST_INSERTED;
            res_nd_nxt = nu_r[NODE_W-1:0];
            nu_nxt     = nu_r + LINK_W'(1);
          end else begin
            res_st_nxt = ST_FULL;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_nd_nxt    = res_nd_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      nu_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      nu_r        <= nu_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    key_r    <= key_nxt;
    dvd_r    <= dvd_nxt;
    rem_r    <= rem_nxt;
    step_r   <= step_nxt;
    bkt_r    <= bkt_nxt;
    res_st_r <= res_st_nxt;
    res_nd_r <= res_nd_nxt;
    out_st_r <= out_st_nxt;
    out_nd_r <= out_nd_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_st_r;
  assign out_node_index = NODE_IDX_W'(out_nd_r);

  `CHS_ASSERT_NOW(a_pool_bound, 1'b1, nu_r <= LINK_W'(POOL_NODES), "pool count overrun")
  `CHS_ASSERT_NEXT(a_ins_bump, do_ins, nu_r == $past(nu_r) + LINK_W'(1), "allocation lost")
  `CHS_ASSERT_NEXT(a_accept_div, in_valid && in_ready, state_r == S_DIV, "request not started")
  `CHS_ASSERT_NOW(a_out_from_done, $rose(out_valid_r), $past(state_r) == S_DONE,
                  "result loaded outside done")
  `CHS_ASSERT_NOW(a_no_ins_clear, state_r == S_CLEAR, !in_ready && !do_ins,
                  "activity during head sweep")
endmodule

// ===== test/chained_hash_set_test.sv =====
// Self-checking testbench for chained_hash_set: random and directed finds and inserts.
module chained_hash_set_test;
  timeunit 1ns;
  timeprecision 1ps;
  import chs_pkg::*;

  localparam int MAX_BUCKETS = 1024;
  localparam int POOL_NODES  = 4096;
  localparam logic KIND_FIND   = 1'b0;
  localparam logic KIND_INSERT = 1'b1;
  localparam int REG_SPARE = 1;  // no register here: writes must be dropped

  typedef struct packed {
    logic             kind;
    logic [KEY_W-1:0] key;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [NODE_IDX_W-1:0] node;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_kind = 1'b0;
  logic [KEY_W-1:0] in_key = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [NODE_IDX_W-1:0] out_node_index;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  chained_hash_set dut (.*);

  // shadow of the set
  logic [CFG_W-1:0]   shadow_buckets = BUCKET_COUNT_RST;
  logic [12:0]        shadow_heads[MAX_BUCKETS];
  logic [KEY_W-1:0]   shadow_keys[POOL_NODES];
  logic [12:0]        shadow_links[POOL_NODES];
  int                 shadow_used = 0;

  request_t      pending_reqs[$];
  answer_t       expected_answers[$];
  logic [KEY_W-1:0] known_keys[$];
  int fails = 0;
  int send_idle = 0, recv_stall = 0;
  int hold_req = 0, hold_seen = 0, hold_left = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int buckets_in_use(logic [CFG_W-1:0] n);
    if (n == 0) return 1;
    if (n > MAX_BUCKETS) return MAX_BUCKETS;
    return n;
  endfunction

  task automatic predict_answer(logic kind, logic [KEY_W-1:0] key);
    int bucket;
    int link;
    int steps;
    answer_t a;
    bucket = key % buckets_in_use(shadow_buckets);
    link = shadow_heads[bucket];
    steps = 0;
    a.status = ST_NOT_FOUND;
    a.node = '0;
    while (link != 0 && steps < POOL_NODES && link - 1 < shadow_used) begin
      if (shadow_keys[link-1] == key) begin
        a.status = ST_FOUND;
        a.node = NODE_IDX_W'(link - 1);
        break;
      end
      link = shadow_links[link-1];
      steps++;
    end
    if (a.status != ST_FOUND && kind == KIND_INSERT) begin
      if (shadow_used >= POOL_NODES) begin
        a.status = ST_FULL;
      end else begin
        shadow_keys[shadow_used] = key;
        shadow_links[shadow_used] = shadow_heads[bucket];
        shadow_heads[bucket] = 13'(shadow_used + 1);
        a.status = ST_INSERTED;
        a.node = NODE_IDX_W'(shadow_used);
        shadow_used++;
      end
    end
    expected_answers.push_back(a);
  endtask

  // driver: a word is predicted at the edge it is taken
  always @(posedge clk) begin
    request_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_answer(in_kind, in_key);
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
          r = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_kind <= r.kind;
          in_key <= r.key;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk) begin
    answer_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_answers.size() == 0) begin
          $error("unexpected word: status %0d node %0d", out_status, out_node_index);
          fails++;
        end else begin
          e = expected_answers.pop_front();
          if (out_status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, out_status);
            fails++;
          end
          if (out_node_index !== e.node) begin
            $error("node_index: expected %0d, got %0d", e.node, out_node_index);
            fails++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        hold_left <= 400;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  task automatic reg_write(int idx, logic [PDATA_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= PADDR_W'(4 * idx); pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_BUCKET_COUNT) shadow_buckets = value[CFG_W-1:0];
  endtask

  // sampled at the falling edge, once the driver's updates have settled
  task automatic drain;
    while (pending_reqs.size() > 0 || expected_answers.size() > 0 || in_valid)
      @(negedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic push_req(logic kind, logic [KEY_W-1:0] key);
    request_t r;
    r.kind = kind;
    r.key = key;
    pending_reqs.push_back(r);
    if (kind == KIND_INSERT) known_keys.push_back(key);
  endtask

  // mostly keys already seen or sharing their bucket, so chains get walked
  task automatic push_random(int count);
    int pick;
    logic [KEY_W-1:0] k;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (known_keys.size() == 0 || pick < 35) begin
        k = $urandom;
      end else begin
        k = known_keys[$urandom_range(known_keys.size() - 1)];
        if (pick < 60)
          k = k + KEY_W'(buckets_in_use(shadow_buckets) * $urandom_range(1, 40));
      end
      push_req(logic'($urandom_range(1)), k);
    end
  endtask

  task automatic run_phase(logic [PDATA_W-1:0] buckets, int count, int s_idle, int r_stall);
    reg_write(REG_BUCKET_COUNT, buckets);
    send_idle <= s_idle;
    recv_stall <= r_stall;
    push_random(count);
    drain();
  endtask

  initial begin
    for (int i = 0; i < MAX_BUCKETS; i++) shadow_heads[i] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: edge keys, repeats, one bucket chain of several nodes
    push_req(KIND_FIND, 32'h0);
    push_req(KIND_INSERT, 32'h0);
    push_req(KIND_INSERT, 32'h0);
    push_req(KIND_FIND, 32'h0);
    push_req(KIND_INSERT, 32'hFFFF_FFFF);
    push_req(KIND_FIND, 32'hFFFF_FFFF);
    push_req(KIND_FIND, 32'hFFFF_FFFE);
    push_req(KIND_INSERT, 32'd1021);
    push_req(KIND_INSERT, 32'd7);
    push_req(KIND_INSERT, 32'd1028);
    push_req(KIND_INSERT, 32'd2049);
    push_req(KIND_FIND, 32'd7);
    push_req(KIND_FIND, 32'd1028);
    push_req(KIND_FIND, 32'd3070);
    push_req(KIND_INSERT, 32'd2049);
    push_req(KIND_INSERT, 32'hAAAA_AAAA);
    push_req(KIND_INSERT, 32'h5555_5555);
    push_req(KIND_FIND, 32'h5555_5555);
    drain();

    run_phase(1021, 250, 0, 0);
    reg_write(REG_SPARE, 32'd5);   // must not touch bucket_count
    push_random(60);
    drain();
    run_phase(11, 150, 55, 0);
    run_phase(0, 40, 0, 55);
    // long receiver hold while words keep coming
    reg_write(REG_BUCKET_COUNT, 2047);
    send_idle <= 0;
    recv_stall <= 35;
    push_random(300);
    hold_req <= 1;
    drain();
    run_phase(1024, 200, 55, 0);
    run_phase(13, 100, 0, 55);
    run_phase(1021, 200, 35, 35);

    // dense run of sequential keys, then repeats and misses
    reg_write(REG_BUCKET_COUNT, 1024);
    send_idle <= 0;
    recv_stall <= 20;
    for (int i = 0; i < 100; i++) push_req(KIND_INSERT, 32'hF000_0000 + i);
    push_req(KIND_INSERT, 32'hF000_0003);
    push_req(KIND_FIND, 32'hF000_0005);
    push_req(KIND_FIND, 32'h1234_5678);
    push_req(KIND_INSERT, 32'h1234_5678);
    push_random(40);
    drain();

    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/chs_pkg.sv
rtl/chained_hash_set.sv
test/chained_hash_set_test.sv
